@@ sv/dbe_pkg.sv @@
// ----------------------------------------------------------------------------
// dbe_pkg
// shared codes and defaults for the distributed barrier engine
// ----------------------------------------------------------------------------
package dbe_pkg;

  localparam int unsigned DEF_BARRIER_SLOTS = 256;
  localparam int unsigned DEF_MAX_HOSTS     = 64;
  localparam int unsigned DEF_GEN_BITS      = 32;

  // fixed field widths and the message cap
  localparam int unsigned HOST_W  = 6;
  localparam int unsigned HCNT_W  = 7;
  localparam int unsigned BID_W   = 8;
  localparam int unsigned PART_W  = 16;
  localparam int unsigned MGEN_W  = 32;
  localparam int unsigned MASK_W  = 64;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned MAX_MSG = 63;

  localparam logic [1:0] OP_LOCAL  = 2'd0;
  localparam logic [1:0] OP_REMOTE = 2'd1;
  localparam logic [1:0] OP_BREAK  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVAL   = 2'd1;
  localparam logic [1:0] ST_FAILPRE = 2'd2;

  localparam logic [1:0] WAKE_NONE = 2'd0;
  localparam logic [1:0] WAKE_ADV  = 2'd1;
  localparam logic [1:0] WAKE_BRK  = 2'd2;

  localparam logic KIND_ARRIVE  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [1:0] CFG_LOCAL_HOST = 2'd0;
  localparam logic [1:0] CFG_HOST_COUNT = 2'd1;
  localparam logic [1:0] CFG_LINK       = 2'd2;

endpackage

@@ sv/dbe_table.sv @@
// ----------------------------------------------------------------------------
// dbe_table
// barrier slot table: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module dbe_table #(
  parameter int unsigned SLOTS   = dbe_pkg::DEF_BARRIER_SLOTS,
  parameter int unsigned ENTRY_W = 8,
  parameter int unsigned ADDR_W  = 8
) (
  input  logic               clk_i,
  input  logic               rd_en_i,
  input  logic [ADDR_W-1:0]  rd_addr_i,
  output logic [ENTRY_W-1:0] rd_data_o,
  input  logic               wr_en_i,
  input  logic [ADDR_W-1:0]  wr_addr_i,
  input  logic [ENTRY_W-1:0] wr_data_i
);

  logic [ENTRY_W-1:0] mem_q [SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

@@ sv/distributed_barrier_engine_top.sv @@
// ----------------------------------------------------------------------------
// distributed_barrier_engine_top
// per-host barrier unit: slot table read-modify-write plus message sequencer
// ----------------------------------------------------------------------------
// sequence: table read, then evaluation, then the first result beat is
//   registered; the final beat follows the outgoing message beats
// bursts: one outgoing message per cycle while the output is not stalled, up
//   to 63 per item, failure bursts skip the local host; a new item is taken
//   only after the final beat of the item before it is loaded
// reset: asynchronous; afterwards a clearing pass zeroes every table slot
//   while input is stalled; config writes are taken as ever
module distributed_barrier_engine_top #(
  parameter int unsigned BARRIER_SLOTS = dbe_pkg::DEF_BARRIER_SLOTS,
  parameter int unsigned MAX_HOSTS     = dbe_pkg::DEF_MAX_HOSTS,
  parameter int unsigned GEN_BITS      = dbe_pkg::DEF_GEN_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  bar_id_i,
  input  logic [15:0] participants_i,
  input  logic        msg_kind_i,
  input  logic [5:0]  source_i,
  input  logic [31:0] generation_i,
  input  logic        failed_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        send_valid_o,
  output logic        out_kind_o,
  output logic [5:0]  dest_host_o,
  output logic [7:0]  msg_barrier_o,
  output logic [31:0] msg_generation_o,
  output logic        msg_failed_o,
  output logic [1:0]  status_o,
  output logic [1:0]  wake_o,
  output logic        last_o
);

  localparam int unsigned SLOT_W = (BARRIER_SLOTS > 1) ? $clog2(BARRIER_SLOTS) : 1;
  localparam int unsigned CLR_W  = SLOT_W + 1;
  localparam logic [dbe_pkg::HCNT_W-1:0] MAXH = dbe_pkg::HCNT_W'(MAX_HOSTS);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(BARRIER_SLOTS - 1);

  // one table row
  typedef struct packed {
    logic [GEN_BITS-1:0]        gen;
    logic [dbe_pkg::PART_W-1:0] expct;
    logic [dbe_pkg::PART_W-1:0] arr;
    logic [dbe_pkg::MASK_W-1:0] mask;
    logic                       rep;
    logic                       brk;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EVAL, S_EMIT, S_FINAL
  } state_e;

  // kind of message burst an item causes
  typedef enum logic [1:0] {
    EM_NONE, EM_SINGLE, EM_REL, EM_FAIL
  } emit_e;

  state_e state_q;

  // configuration registers
  logic [dbe_pkg::HOST_W-1:0] local_host_q;
  logic [dbe_pkg::HCNT_W-1:0] host_count_q;
  logic                       link_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_host_q <= '0;
      host_count_q <= dbe_pkg::HCNT_W'(1);
      link_q       <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dbe_pkg::CFG_LOCAL_HOST: local_host_q <= cfg_data_i[dbe_pkg::HOST_W-1:0];
        dbe_pkg::CFG_HOST_COUNT: host_count_q <= cfg_data_i;
        dbe_pkg::CFG_LINK:       link_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // slot = bar_id mod BARRIER_SLOTS, restoring reduction by the constant
  logic [19:0]       mod_r;
  logic [19:0]       mod_d;
  logic [SLOT_W-1:0] in_slot;

  always_comb begin
    mod_r = {12'd0, bar_id_i};
    for (int i = 7; i >= 0; i--) begin
      mod_d = 20'(BARRIER_SLOTS) << i;
      if (mod_r >= mod_d) begin
        mod_r = mod_r - mod_d;
      end
    end
    in_slot = mod_r[SLOT_W-1:0];
  end

  // captured item
  logic [1:0]                 op_q;
  logic [dbe_pkg::BID_W-1:0]  bid_q;
  logic [dbe_pkg::PART_W-1:0] parts_q;
  logic                       kind_q;
  logic [dbe_pkg::HOST_W-1:0] src_q;
  logic [31:0]                igen_q;
  logic                       fail_q;
  logic [SLOT_W-1:0]          slot_q;

  logic in_acc;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= op_i;
      bid_q   <= bar_id_i;
      parts_q <= participants_i;
      kind_q  <= msg_kind_i;
      src_q   <= source_i;
      igen_q  <= generation_i;
      fail_q  <= failed_i;
      slot_q  <= in_slot;
    end
  end

  // slot table
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [CLR_W-1:0]   clr_q;

  dbe_table #(
    .SLOTS   (BARRIER_SLOTS),
    .ENTRY_W (ENTRY_W),
    .ADDR_W  (SLOT_W)
  ) u_table (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (in_slot),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // evaluation of one item against the row read back
  entry_t                     ent, ent_n;
  logic [1:0]                 ev_st, ev_wk;
  emit_e                      ev_mode;
  logic                       ev_we;
  logic                       brk_req, arv_req, adv_req;
  logic [dbe_pkg::HOST_W-1:0] arv_src;
  logic [dbe_pkg::HCNT_W-1:0] span_n;
  logic [dbe_pkg::MASK_W-1:0] all_m, mask_up;
  logic [GEN_BITS-1:0]        in_gen;
  logic [63:0]                igen_ext;
  logic                       bad_world;
  logic [dbe_pkg::PART_W-1:0] arr_inc;

  assign ent      = entry_t'(rd_data);
  assign span_n   = (host_count_q > MAXH) ? MAXH : host_count_q;
  assign all_m    = (span_n >= dbe_pkg::HCNT_W'(64)) ? '1
                                                     : ((64'd1 << span_n) - 64'd1);
  assign igen_ext = {32'd0, igen_q};
  assign in_gen   = igen_ext[GEN_BITS-1:0];
  assign arr_inc  = ent.arr + dbe_pkg::PART_W'(1);
  assign bad_world = (host_count_q == '0) || (host_count_q > MAXH) ||
                     ({1'b0, local_host_q} >= host_count_q) ||
                     ((host_count_q > dbe_pkg::HCNT_W'(1)) && !link_q);

  always_comb begin
    ent_n   = ent;
    ev_st   = dbe_pkg::ST_OK;
    ev_wk   = dbe_pkg::WAKE_NONE;
    ev_mode = EM_NONE;
    ev_we   = 1'b0;
    brk_req = 1'b0;
    arv_req = 1'b0;
    adv_req = 1'b0;
    arv_src = '0;
    mask_up = '0;
    case (op_q)
      dbe_pkg::OP_LOCAL: begin
        if (parts_q == '0) begin
          ev_st = dbe_pkg::ST_INVAL;
        end else if (bad_world || ent.brk) begin
          ev_st = dbe_pkg::ST_FAILPRE;
        end else if (ent.expct != '0 && ent.expct != parts_q) begin
          brk_req = 1'b1;
          ev_st   = dbe_pkg::ST_INVAL;
        end else begin
          ent_n.expct = parts_q;
          ev_we       = 1'b1;
          if (ent.rep) begin
            brk_req = 1'b1;
            ev_st   = dbe_pkg::ST_FAILPRE;
          end else begin
            ent_n.arr = arr_inc;
            if (arr_inc == parts_q) begin
              ent_n.rep = 1'b1;
              if (local_host_q == '0) begin
                arv_req = 1'b1;
              end else begin
                ev_mode = EM_SINGLE;
              end
            end
          end
        end
      end
      dbe_pkg::OP_REMOTE: begin
        if ({1'b0, src_q} >= host_count_q) begin
          ev_st = dbe_pkg::ST_INVAL;
        end else if (fail_q) begin
          if (kind_q != dbe_pkg::KIND_RELEASE) begin
            ev_st = dbe_pkg::ST_INVAL;
          end else begin
            ent_n.brk = 1'b1;
            ev_wk     = dbe_pkg::WAKE_BRK;
            ev_we     = 1'b1;
          end
        end else if (ent.brk || in_gen < ent.gen) begin
          ev_st = dbe_pkg::ST_OK;
        end else if (in_gen != ent.gen) begin
          brk_req = 1'b1;
        end else if (kind_q == dbe_pkg::KIND_ARRIVE && local_host_q == '0 &&
                     src_q != '0) begin
          arv_req = 1'b1;
          arv_src = src_q;
        end else if (kind_q == dbe_pkg::KIND_RELEASE && local_host_q != '0 &&
                     src_q == '0 && ent.rep) begin
          adv_req = 1'b1;
        end else begin
          brk_req = 1'b1;
        end
      end
      dbe_pkg::OP_BREAK: begin
        brk_req = 1'b1;
      end
      default: begin
        ev_st = dbe_pkg::ST_INVAL;
      end
    endcase

    // host arrival at the collecting host
    if (arv_req) begin
      mask_up    = ent_n.mask | (64'd1 << arv_src);
      ent_n.mask = mask_up;
      ev_we      = 1'b1;
      if (mask_up == all_m) begin
        adv_req = 1'b1;
        if (link_q) begin
          ev_mode = EM_REL;
        end
      end
    end
    // generation advance
    if (adv_req) begin
      ent_n.gen  = ent.gen + GEN_BITS'(1);
      ent_n.arr  = '0;
      ent_n.mask = '0;
      ent_n.rep  = 1'b0;
      ev_wk      = dbe_pkg::WAKE_ADV;
      ev_we      = 1'b1;
    end
    // break, sticky
    if (brk_req && !ent.brk) begin
      ent_n.brk = 1'b1;
      ev_wk     = dbe_pkg::WAKE_BRK;
      ev_we     = 1'b1;
      if (link_q) begin
        ev_mode = EM_FAIL;
      end
    end
  end

  assign wr_en   = (state_q == S_CLEAR) || ((state_q == S_EVAL) && ev_we);
  assign wr_addr = (state_q == S_CLEAR) ? clr_q[SLOT_W-1:0] : slot_q;
  assign wr_data = (state_q == S_CLEAR) ? '0 : ENTRY_W'(ent_n);

  // message sequencer and output register
  emit_e                      mode_q;
  logic [dbe_pkg::HCNT_W-1:0] h_q, end_q;
  logic [5:0]                 cnt_q;
  logic [GEN_BITS-1:0]        egen_q;
  logic [63:0]                egen_ext;
  logic [1:0]                 st_q, wk_q;
  logic                       out_free;
  logic                       emit_stop, emit_skip, out_load;

  assign egen_ext  = 64'(egen_q);
  assign out_free  = !out_valid_o || !out_stall_i;
  assign emit_stop = (h_q >= end_q) || (cnt_q == 6'(dbe_pkg::MAX_MSG));
  assign emit_skip = (mode_q == EM_FAIL) && (h_q == {1'b0, local_host_q});
  // a beat is loaded into the output register in this cycle
  assign out_load  = out_free && (((state_q == S_EMIT) && !emit_stop && !emit_skip) ||
                                  (state_q == S_FINAL));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_CLEAR;
      clr_q            <= '0;
      mode_q           <= EM_NONE;
      h_q              <= '0;
      end_q            <= '0;
      cnt_q            <= '0;
      egen_q           <= '0;
      st_q             <= dbe_pkg::ST_OK;
      wk_q             <= dbe_pkg::WAKE_NONE;
      out_valid_o      <= 1'b0;
      send_valid_o     <= 1'b0;
      out_kind_o       <= 1'b0;
      dest_host_o      <= '0;
      msg_barrier_o    <= '0;
      msg_generation_o <= '0;
      msg_failed_o     <= 1'b0;
      status_o         <= dbe_pkg::ST_OK;
      wake_o           <= dbe_pkg::WAKE_NONE;
      last_o           <= 1'b0;
    end else begin
      out_valid_o <= out_load || (out_valid_o && out_stall_i);
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + CLR_W'(1);
          if (clr_q == CLR_LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          mode_q <= ev_mode;
          st_q   <= ev_st;
          wk_q   <= ev_wk;
          egen_q <= ent.gen;
          cnt_q  <= '0;
          h_q    <= (ev_mode == EM_REL) ? dbe_pkg::HCNT_W'(1) : '0;
          end_q  <= (ev_mode == EM_SINGLE) ? dbe_pkg::HCNT_W'(1) : span_n;
          state_q <= (ev_mode == EM_NONE) ? S_FINAL : S_EMIT;
        end
        S_EMIT: begin
          if (emit_stop) begin
            state_q <= S_FINAL;
          end else if (emit_skip) begin
            h_q <= h_q + dbe_pkg::HCNT_W'(1);
          end else if (out_free) begin
            send_valid_o     <= 1'b1;
            out_kind_o       <= (mode_q == EM_SINGLE) ? dbe_pkg::KIND_ARRIVE
                                                      : dbe_pkg::KIND_RELEASE;
            dest_host_o      <= h_q[dbe_pkg::HOST_W-1:0];
            msg_barrier_o    <= bid_q;
            msg_generation_o <= egen_ext[31:0];
            msg_failed_o     <= (mode_q == EM_FAIL);
            status_o         <= dbe_pkg::ST_OK;
            wake_o           <= dbe_pkg::WAKE_NONE;
            last_o           <= 1'b0;
            h_q              <= h_q + dbe_pkg::HCNT_W'(1);
            cnt_q            <= cnt_q + 6'd1;
          end
        end
        S_FINAL: begin
          if (out_free) begin
            send_valid_o     <= 1'b0;
            out_kind_o       <= 1'b0;
            dest_host_o      <= '0;
            msg_barrier_o    <= '0;
            msg_generation_o <= '0;
            msg_failed_o     <= 1'b0;
            status_o         <= st_q;
            wake_o           <= wk_q;
            last_o           <= 1'b1;
            state_q          <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // a stalled result beat is never dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // the table is only written by the clearing pass or an evaluation
  a_wr_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_CLEAR || state_q == S_EVAL))
    else $error("unexpected table write");

  // an accepted beat is evaluated in the next cycle
  a_acc_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_EVAL)
    else $error("accepted beat not evaluated");

  // burst never exceeds the message cap
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_valid_o |-> cnt_q <= 6'(dbe_pkg::MAX_MSG) && cnt_q != '0)
    else $error("message count out of range");
`endif

endmodule
